/* sv/bscc_pkg.sv */
// bscc_pkg: item types, turn codes and small arithmetic helpers for the
// box / segment contact classifier. No dependencies.
package bscc_pkg;

	localparam int NUM_EDGES = 4;
	localparam int TURNS_PER_EDGE = 4;
	localparam int NUM_TURNS = NUM_EDGES * TURNS_PER_EDGE;

	// box edge indices into the per-edge turn arrays
	localparam int EDGE_LEFT = 0;
	localparam int EDGE_RIGHT = 1;
	localparam int EDGE_TOP = 2;
	localparam int EDGE_BOTTOM = 3;

	// orientation of an ordered point triple
	typedef enum logic [1:0] {
		TURN_COL = 2'd0,
		TURN_POS = 2'd1,
		TURN_NEG = 2'd2
	} turn_t;

	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic [11:0] box_width;
		logic [11:0] box_height;
		logic signed [15:0] seg_start_x;
		logic signed [15:0] seg_start_y;
		logic signed [15:0] seg_end_x;
		logic signed [15:0] seg_end_y;
	} in_item_t;

	typedef struct packed {
		logic floor_contact;
		logic wall_nearer_right_edge;
		logic wall_nearer_left_edge;
	} out_item_t;

	// point with room for left + width and top + height
	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
	} pt_t;

	// operands of one cross product: dy_ab*dx_bc - dx_ab*dy_bc
	typedef struct packed {
		logic signed [17:0] dy_ab;
		logic signed [17:0] dx_bc;
		logic signed [17:0] dx_ab;
		logic signed [17:0] dy_bc;
	} turn_ops_t;

	function automatic logic signed [16:0] sext17(input logic signed [15:0] v);
		return {v[15], v};
	endfunction

	function automatic logic signed [17:0] sub18(input logic signed [16:0] a,
			input logic signed [16:0] b);
		return {a[16], a} - {b[16], b};
	endfunction

	function automatic logic [17:0] abs18(input logic signed [17:0] v);
		return v[17] ? 18'(-v) : 18'(v);
	endfunction

	// m lies inside the bounding box of a and b
	function automatic logic within_bbox(input pt_t a, input pt_t m, input pt_t b);
		logic signed [16:0] xlo, xhi, ylo, yhi;
		xlo = (a.x < b.x) ? a.x : b.x;
		xhi = (a.x < b.x) ? b.x : a.x;
		ylo = (a.y < b.y) ? a.y : b.y;
		yhi = (a.y < b.y) ? b.y : a.y;
		return (m.x >= xlo) && (m.x <= xhi) && (m.y >= ylo) && (m.y <= yhi);
	endfunction

endpackage

/* sv/box_segment_contact_classifier.sv */
// box_segment_contact_classifier: five-stage pipelined box / segment
// contact test. Depends on bscc_pkg.
//
// Usage:
//   Input channel: drive item and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy is always low,
//   so one item may be issued every clock cycle.
//   Result channel: done is high for exactly one cycle with result valid
//   in that cycle. Exactly one result per item, in issue order.
//   Stages: s1 edge points, s2 differences and bbox checks, s3 cross
//   products, s4 orientation codes, s5 contact flags; done and result
//   are driven from the s5 registers.
//   Throughput: one item per cycle, set by the fully pipelined datapath;
//   16 orientation tests run in parallel, each with two 18x18 multiplies.
//   Reset: arst_n low clears all stage valid bits; items in flight are
//   dropped and done stays low until new items arrive.
//   The receiver cannot stall: results are presented once and not held.
module box_segment_contact_classifier
	import bscc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	// never back-pressures: every stage advances each cycle
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: box corners and segment endpoints
	logic v_s1;
	pt_t tl_s1, tr_s1, bl_s1, br_s1, s_s1, e_s1;
	logic vert_s1;

	// ---------------- stage 2: cross product operands, bbox checks, distances
	logic v_s2;
	turn_ops_t ops_s2 [NUM_TURNS];
	logic [NUM_TURNS-1:0] win_s2;
	logic vert_s2;
	logic signed [17:0] dr_s2, dl_s2;

	// ---------------- stage 3: products
	logic v_s3;
	logic signed [35:0] pa_s3 [NUM_TURNS];
	logic signed [35:0] pb_s3 [NUM_TURNS];
	logic [NUM_TURNS-1:0] win_s3;
	logic vert_s3, lt_s3, gt_s3;

	// ---------------- stage 4: orientation codes
	logic v_s4;
	turn_t turn_s4 [NUM_TURNS];
	logic [NUM_TURNS-1:0] win_s4;
	logic vert_s4, lt_s4, gt_s4;

	// ---------------- stage 5: output
	logic v_s5;
	out_item_t res_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		logic signed [16:0] lx, ty, rx, by;
		lx = sext17(item.box_left);
		ty = sext17(item.box_top);
		rx = lx + $signed({5'b0, item.box_width});
		by = ty + $signed({5'b0, item.box_height});
		tl_s1 <= '{x: lx, y: ty};
		tr_s1 <= '{x: rx, y: ty};
		bl_s1 <= '{x: lx, y: by};
		br_s1 <= '{x: rx, y: by};
		s_s1 <= '{x: sext17(item.seg_start_x), y: sext17(item.seg_start_y)};
		e_s1 <= '{x: sext17(item.seg_end_x), y: sext17(item.seg_end_y)};
		// a degenerate segment counts as vertical too
		vert_s1 <= (item.seg_start_x == item.seg_end_x);
	end

	// stage 2: per edge, triples (e1,e2,s) (e1,e2,e) (s,e,e1) (s,e,e2);
	// each triple (a,b,c) also checks c inside the bbox of a and b
	pt_t edge_a [NUM_EDGES];
	pt_t edge_b [NUM_EDGES];
	pt_t tri_a [NUM_TURNS];
	pt_t tri_b [NUM_TURNS];
	pt_t tri_c [NUM_TURNS];

	always_comb begin
		edge_a[EDGE_LEFT] = tl_s1;
		edge_b[EDGE_LEFT] = bl_s1;
		edge_a[EDGE_RIGHT] = tr_s1;
		edge_b[EDGE_RIGHT] = br_s1;
		edge_a[EDGE_TOP] = tl_s1;
		edge_b[EDGE_TOP] = tr_s1;
		edge_a[EDGE_BOTTOM] = bl_s1;
		edge_b[EDGE_BOTTOM] = br_s1;
		for (int k = 0; k < NUM_EDGES; k++) begin
			tri_a[TURNS_PER_EDGE*k + 0] = edge_a[k];
			tri_b[TURNS_PER_EDGE*k + 0] = edge_b[k];
			tri_c[TURNS_PER_EDGE*k + 0] = s_s1;
			tri_a[TURNS_PER_EDGE*k + 1] = edge_a[k];
			tri_b[TURNS_PER_EDGE*k + 1] = edge_b[k];
			tri_c[TURNS_PER_EDGE*k + 1] = e_s1;
			tri_a[TURNS_PER_EDGE*k + 2] = s_s1;
			tri_b[TURNS_PER_EDGE*k + 2] = e_s1;
			tri_c[TURNS_PER_EDGE*k + 2] = edge_a[k];
			tri_a[TURNS_PER_EDGE*k + 3] = s_s1;
			tri_b[TURNS_PER_EDGE*k + 3] = e_s1;
			tri_c[TURNS_PER_EDGE*k + 3] = edge_b[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TURNS; i++) begin
			ops_s2[i].dy_ab <= sub18(tri_b[i].y, tri_a[i].y);
			ops_s2[i].dx_bc <= sub18(tri_c[i].x, tri_b[i].x);
			ops_s2[i].dx_ab <= sub18(tri_b[i].x, tri_a[i].x);
			ops_s2[i].dy_bc <= sub18(tri_c[i].y, tri_b[i].y);
			win_s2[i] <= within_bbox(tri_a[i], tri_c[i], tri_b[i]);
		end
		vert_s2 <= vert_s1;
		dr_s2 <= sub18(tr_s1.x, s_s1.x);
		dl_s2 <= sub18(tl_s1.x, s_s1.x);
	end

	// stage 3
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TURNS; i++) begin
			pa_s3[i] <= ops_s2[i].dy_ab * ops_s2[i].dx_bc;
			pb_s3[i] <= ops_s2[i].dx_ab * ops_s2[i].dy_bc;
		end
		win_s3 <= win_s2;
		vert_s3 <= vert_s2;
		lt_s3 <= abs18(dr_s2) < abs18(dl_s2);
		gt_s3 <= abs18(dr_s2) > abs18(dl_s2);
	end

	// stage 4
	always_ff @(posedge clk) begin
		logic signed [36:0] cr;
		for (int i = 0; i < NUM_TURNS; i++) begin
			cr = {pa_s3[i][35], pa_s3[i]} - {pb_s3[i][35], pb_s3[i]};
			if (cr == '0) begin
				turn_s4[i] <= TURN_COL;
			end else if (cr[36]) begin
				turn_s4[i] <= TURN_NEG;
			end else begin
				turn_s4[i] <= TURN_POS;
			end
		end
		win_s4 <= win_s3;
		vert_s4 <= vert_s3;
		lt_s4 <= lt_s3;
		gt_s4 <= gt_s3;
	end

	// stage 5: segment meets each edge (crossing or collinear touch)
	logic [NUM_EDGES-1:0] meet;

	always_comb begin
		for (int k = 0; k < NUM_EDGES; k++) begin
			meet[k] =
				((turn_s4[TURNS_PER_EDGE*k + 0] != turn_s4[TURNS_PER_EDGE*k + 1]) &&
				 (turn_s4[TURNS_PER_EDGE*k + 2] != turn_s4[TURNS_PER_EDGE*k + 3])) ||
				((turn_s4[TURNS_PER_EDGE*k + 0] == TURN_COL) && win_s4[TURNS_PER_EDGE*k + 0]) ||
				((turn_s4[TURNS_PER_EDGE*k + 1] == TURN_COL) && win_s4[TURNS_PER_EDGE*k + 1]) ||
				((turn_s4[TURNS_PER_EDGE*k + 2] == TURN_COL) && win_s4[TURNS_PER_EDGE*k + 2]) ||
				((turn_s4[TURNS_PER_EDGE*k + 3] == TURN_COL) && win_s4[TURNS_PER_EDGE*k + 3]);
		end
	end

	always_ff @(posedge clk) begin
		logic wall;
		wall = vert_s4 && meet[EDGE_TOP] && meet[EDGE_BOTTOM];
		res_s5.floor_contact <= !vert_s4 && (meet[EDGE_LEFT] || meet[EDGE_RIGHT]);
		res_s5.wall_nearer_right_edge <= wall && lt_s4;
		res_s5.wall_nearer_left_edge <= wall && gt_s4;
	end

	assign done = v_s5;
	assign result = res_s5;

	// ---------------- assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted item did not produce a result after 5 cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result without a matching item");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({result.floor_contact, result.wall_nearer_right_edge,
			result.wall_nearer_left_edge}))
		else $error("floor and wall flags raised together");

endmodule
